// ===== hdl/integer_power_square_multiply_defines.svh =====
// Assertion macros shared by the integer power block.
`ifndef INTEGER_POWER_SQUARE_MULTIPLY_DEFINES_SVH
`define INTEGER_POWER_SQUARE_MULTIPLY_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IPSM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("integer power: implication violated");

// The consequent must hold in the cycle after the antecedent.
`define IPSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("integer power: sequence violated");

// The expression must never be true.
`define IPSM_ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("integer power: forbidden condition");

`endif

// ===== hdl/ipsm_pkg.sv =====
`timescale 1ns / 1ps
package ipsm_pkg;

	localparam logic [63:0] DBL_ONE  = 64'h3FF0_0000_0000_0000;
	localparam logic [63:0] DBL_PINF = 64'h7FF0_0000_0000_0000;
	localparam logic [10:0] EXP_MAX  = 11'h7FF;
	localparam logic [10:0] CONV_EXP = 11'd1054;

	typedef struct packed {
		logic load;
		logic conv_step;
		logic sq_init;
		logic mul_start;
		logic mul_sq;
		logic mag_shift;
		logic take_prod;
		logic take_sq;
		logic rcp_start;
		logic take_rcp;
		logic out_write;
	} cmd_t;

	typedef struct packed {
		logic conv_done;
		logic flag;
		logic neg;
		logic mag_zero;
		logic mag_lsb;
		logic mag_rest_zero;
		logic mul_done;
		logic rcp_done;
		logic out_free;
	} sts_t;

endpackage

// ===== hdl/ipsm_fmul.sv =====
`timescale 1ns / 1ps
module ipsm_fmul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] y
);
	import ipsm_pkg::*;

	logic [63:0]  a_q, b_q, y_q;
	logic [105:0] acc_q;
	logic [2:0]   cnt_q;
	logic         run_q, done_q;

	logic [52:0]  ma, mb;
	logic [26:0]  pa, pb;
	logic [53:0]  pp;
	logic [105:0] pp_sh;
	logic         hi, g, st, inc, sgn, a_zero, b_zero, a_inf, b_inf;
	logic [52:0]  sig;
	logic [12:0]  e1;
	logic [62:0]  packed_v, mag_v;

	assign ma = {1'b1, a_q[51:0]};
	assign mb = {1'b1, b_q[51:0]};
	assign pa = cnt_q[1] ? ma[52:26] : {1'b0, ma[25:0]};
	assign pb = cnt_q[0] ? mb[52:26] : {1'b0, mb[25:0]};
	assign pp = pa * pb;

	always_comb begin
		case (cnt_q[1:0])
			2'd0:    pp_sh = {52'b0, pp};
			2'd3:    pp_sh = {pp, 52'b0};
			default: pp_sh = {26'b0, pp, 26'b0};
		endcase
	end

	assign hi  = acc_q[105];
	assign sig = hi ? acc_q[105:53] : acc_q[104:52];
	assign g   = hi ? acc_q[52] : acc_q[51];
	assign st  = hi ? (|acc_q[51:0]) : (|acc_q[50:0]);
	assign inc = g & (st | sig[0]);
	assign e1  = {2'b0, a_q[62:52]} + {2'b0, b_q[62:52]} - 13'd1023 + {12'b0, hi};
	assign a_zero = a_q[62:0] == 63'b0;
	assign b_zero = b_q[62:0] == 63'b0;
	assign a_inf  = a_q[62:52] == EXP_MAX;
	assign b_inf  = b_q[62:52] == EXP_MAX;
	assign sgn    = a_q[63] ^ b_q[63];

	always_comb begin
		if (e1 >= {2'b0, EXP_MAX}) begin
			packed_v = {EXP_MAX, 52'b0};
		end else begin
			packed_v = {e1[10:0], sig[51:0]} + {62'b0, inc};
		end
		if (a_zero || b_zero) begin
			mag_v = 63'b0;
		end else if (a_inf || b_inf) begin
			mag_v = {EXP_MAX, 52'b0};
		end else begin
			mag_v = packed_v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 3'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 3'd0;
			end else if (run_q) begin
				if (cnt_q == 3'd4) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= 106'b0;
		end else if (run_q) begin
			if (cnt_q == 3'd4) begin
				y_q <= {sgn, mag_v};
			end else begin
				acc_q <= acc_q + pp_sh;
			end
		end
	end

	assign done = done_q;
	assign y    = y_q;

endmodule

// ===== hdl/ipsm_frcp.sv =====
`timescale 1ns / 1ps
module ipsm_frcp (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] x,
	output logic        done,
	output logic [63:0] y
);
	import ipsm_pkg::*;

	localparam int          QBITS = 56;
	localparam logic [5:0]  QLAST = 6'(QBITS);

	logic        sgn_q, inf_q, run_q, done_q;
	logic [10:0] e_q;
	logic [52:0] mx_q;
	logic [53:0] rem_q;
	logic [55:0] q_q;
	logic [5:0]  cnt_q;
	logic [63:0] y_q;

	logic        ge, q0, sub, g, st, inc, lost;
	logic [53:0] diff;
	logic [54:0] xw, yw;
	logic [12:0] bsig;
	logic [1:0]  sh;
	logic [52:0] sig;
	logic [62:0] packed_v;

	assign ge   = rem_q >= {1'b0, mx_q};
	assign diff = rem_q - {1'b0, mx_q};

	assign q0   = q_q[55];
	assign xw   = q0 ? {1'b1, 54'b0} : q_q[54:0];
	assign bsig = (q0 ? 13'd2046 : 13'd2045) - {2'b0, e_q};
	assign sub  = bsig[12] || (bsig == 13'd0);
	assign sh   = sub ? (bsig == 13'd0 ? 2'd1 : 2'd2) : 2'd0;
	assign yw   = xw >> sh;

	always_comb begin
		case (sh)
			2'd1:    lost = xw[0];
			2'd2:    lost = |xw[1:0];
			default: lost = 1'b0;
		endcase
	end

	assign sig = yw[54:2];
	assign g   = yw[1];
	assign st  = yw[0] | lost | (|rem_q);
	assign inc = g & (st | sig[0]);

	always_comb begin
		if (sub) begin
			packed_v = {11'b0, sig[51:0]} + {62'b0, inc};
		end else begin
			packed_v = {bsig[10:0], sig[51:0]} + {62'b0, inc};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 6'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 6'd0;
			end else if (run_q) begin
				if (cnt_q == QLAST) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 6'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sgn_q <= x[63];
			inf_q <= x[62:52] == EXP_MAX;
			e_q   <= x[62:52];
			mx_q  <= {1'b1, x[51:0]};
			rem_q <= {2'b01, 52'b0};
			q_q   <= 56'b0;
		end else if (run_q) begin
			if (cnt_q == QLAST) begin
				y_q <= inf_q ? {sgn_q, 63'b0} : {sgn_q, packed_v};
			end else begin
				q_q   <= {q_q[54:0], ge};
				rem_q <= ge ? {diff[52:0], 1'b0} : {rem_q[52:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign y    = y_q;

endmodule

// ===== hdl/ipsm_dp.sv =====
`timescale 1ns / 1ps
module ipsm_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  ipsm_pkg::cmd_t     cmd,
	output ipsm_pkg::sts_t     sts,
	input  logic signed [31:0] base,
	input  logic signed [31:0] exponent,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [63:0]        result_bits,
	output logic               undefined_flag
);
	import ipsm_pkg::*;

	logic [31:0] cm_q, mag_q;
	logic [10:0] ce_q;
	logic        bsign_q, neg_q, flag_q, ovalid_q, oflag_q;
	logic [63:0] sq_q, prod_q, ores_q;
	logic        mul_done, rcp_done;
	logic [63:0] mul_y, rcp_y;

	ipsm_fmul u_fmul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.mul_start),
		.a     (cmd.mul_sq ? sq_q : prod_q),
		.b     (sq_q),
		.done  (mul_done),
		.y     (mul_y)
	);

	ipsm_frcp u_frcp (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.rcp_start),
		.x     (prod_q),
		.done  (rcp_done),
		.y     (rcp_y)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bsign_q <= base[31];
			cm_q    <= base[31] ? 32'(-base) : 32'(base);
			ce_q    <= CONV_EXP;
			neg_q   <= exponent[31];
			mag_q   <= exponent[31] ? 32'(-exponent) : 32'(exponent);
			flag_q  <= exponent[31] && (base == 32'sd0);
			prod_q  <= DBL_ONE;
		end else begin
			if (cmd.conv_step) begin
				cm_q <= {cm_q[30:0], 1'b0};
				ce_q <= ce_q - 11'd1;
			end
			if (cmd.sq_init) begin
				sq_q <= (cm_q == 32'd0) ? 64'd0 : {bsign_q, ce_q, cm_q[30:0], 21'b0};
			end
			if (cmd.mag_shift) begin
				mag_q <= {1'b0, mag_q[31:1]};
			end
			if (cmd.take_prod) begin
				prod_q <= mul_y;
			end
			if (cmd.take_sq) begin
				sq_q <= mul_y;
			end
			if (cmd.take_rcp) begin
				prod_q <= rcp_y;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.out_write) begin
			ovalid_q <= 1'b1;
		end else if (!result_stall) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_write) begin
			ores_q  <= flag_q ? DBL_PINF : prod_q;
			oflag_q <= flag_q;
		end
	end

	assign sts.conv_done     = cm_q[31] || (cm_q == 32'd0);
	assign sts.flag          = flag_q;
	assign sts.neg           = neg_q;
	assign sts.mag_zero      = mag_q == 32'd0;
	assign sts.mag_lsb       = mag_q[0];
	assign sts.mag_rest_zero = mag_q[31:1] == 31'd0;
	assign sts.mul_done      = mul_done;
	assign sts.rcp_done      = rcp_done;
	assign sts.out_free      = !ovalid_q || !result_stall;

	assign result_valid   = ovalid_q;
	assign result_bits    = ores_q;
	assign undefined_flag = oflag_q;

endmodule

// ===== hdl/ipsm_ctrl.sv =====
`timescale 1ns / 1ps
module ipsm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  ipsm_pkg::sts_t sts,
	output ipsm_pkg::cmd_t cmd
);
	import ipsm_pkg::*;
	`include "integer_power_square_multiply_defines.svh"

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_CONV = 8'b0000_0010,
		ST_LOOP = 8'b0000_0100,
		ST_MULP = 8'b0000_1000,
		ST_SQ   = 8'b0001_0000,
		ST_MULS = 8'b0010_0000,
		ST_RCP  = 8'b0100_0000,
		ST_DONE = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CONV;
				end
			end
			ST_CONV: begin
				if (!sts.conv_done) begin
					cmd.conv_step = 1'b1;
				end else begin
					cmd.sq_init = 1'b1;
					state_d     = sts.flag ? ST_DONE : ST_LOOP;
				end
			end
			ST_LOOP: begin
				if (sts.mag_zero) begin
					if (sts.neg) begin
						cmd.rcp_start = 1'b1;
						state_d       = ST_RCP;
					end else begin
						state_d = ST_DONE;
					end
				end else if (sts.mag_lsb) begin
					cmd.mul_start = 1'b1;
					state_d       = ST_MULP;
				end else begin
					state_d = ST_SQ;
				end
			end
			ST_MULP: begin
				if (sts.mul_done) begin
					cmd.take_prod = 1'b1;
					state_d       = ST_SQ;
				end
			end
			ST_SQ: begin
				cmd.mag_shift = 1'b1;
				if (sts.mag_rest_zero) begin
					state_d = ST_LOOP;
				end else begin
					cmd.mul_start = 1'b1;
					cmd.mul_sq    = 1'b1;
					state_d       = ST_MULS;
				end
			end
			ST_MULS: begin
				if (sts.mul_done) begin
					cmd.take_sq = 1'b1;
					state_d     = ST_LOOP;
				end
			end
			ST_RCP: begin
				if (sts.rcp_done) begin
					cmd.take_rcp = 1'b1;
					state_d      = ST_DONE;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_write = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign item_stall = state_q != ST_IDLE;

	`IPSM_ASSERT_NEXT(a_accept_conv, clk, arst_n, item_valid && !item_stall, state_q == ST_CONV)
	`IPSM_ASSERT_IMP(a_write_free, clk, arst_n, cmd.out_write, sts.out_free)
	`IPSM_ASSERT_NEVER(a_one_unit, clk, arst_n, cmd.mul_start && cmd.rcp_start)
	`IPSM_ASSERT_IMP(a_mul_wait, clk, arst_n, sts.mul_done,
		state_q == ST_MULP || state_q == ST_MULS)

endmodule

// ===== hdl/integer_power_square_multiply.sv =====
`timescale 1ns / 1ps
// Raises a signed 32-bit integer base to a signed 32-bit integer exponent and
// returns the IEEE double result with a flag for a zero base under a negative
// exponent, in which case the result is positive infinity.
// A word is taken on the item channel when item_valid is high and item_stall
// is low; item_stall is high from the cycle after acceptance until the
// result has been placed in the output register.
// One word is worked on at a time. The base is normalised one bit per cycle,
// then the exponent is scanned from its lowest bit with a single shared
// multiplier, up to two products per exponent bit. A negative exponent adds
// a bit-serial reciprocal.
// The result sits in an output register and is offered on result_valid; a
// new word may be accepted while it waits. If result_stall holds the
// register full when the next result is ready, the controller waits.
// Reset clears all control state; no word is held after reset.
module integer_power_square_multiply (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic signed [31:0] base,
	input  logic signed [31:0] exponent,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [63:0]        result_bits,
	output logic               undefined_flag
);
	import ipsm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	ipsm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	ipsm_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.base          (base),
		.exponent      (exponent),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.result_bits   (result_bits),
		.undefined_flag(undefined_flag)
	);

endmodule
